### sv/nsv_pkg.sv
// Package for the NMEA sentence validator: error codes, the verdict struct
// and the hex digit decoder. No dependencies.
`default_nettype none

package nsv_pkg;

	// Characters the parser looks for
	localparam logic [7:0] CHAR_DOLLAR = 8'h24;
	localparam logic [7:0] CHAR_STAR   = 8'h2A;
	localparam logic [7:0] CHAR_CR     = 8'h0D;
	localparam logic [7:0] CHAR_LF     = 8'h0A;

	// Body count saturates at this value
	localparam logic [2:0] BODY_CNT_MAX = 3'd7;

	// Verdict codes
	localparam logic [2:0] ERR_OK       = 3'd0;
	localparam logic [2:0] ERR_NODOLLAR = 3'd1;
	localparam logic [2:0] ERR_SHORT    = 3'd2;
	localparam logic [2:0] ERR_DIGITS   = 3'd3;
	localparam logic [2:0] ERR_MISMATCH = 3'd4;
	localparam logic [2:0] ERR_STRICT   = 3'd5;
	localparam logic [2:0] ERR_TERM     = 3'd6;

	// Width of the packed result on the output stream
	localparam int RESULT_BYTES = 2;

	// One verdict, as handed from the parser to the output register
	typedef struct packed {
		logic [7:0] computed_xor;
		logic [2:0] error_code;
		logic       sentence_ok;
	} nsv_result_t;

	// Hex digit decode: bit 4 set means the byte is not a hex digit
	function automatic logic [4:0] hex_value(input logic [7:0] b);
		logic [4:0] v;
		v = 5'h10;
		if (b >= 8'h30 && b <= 8'h39) begin
			v = 5'(b - 8'h30);
		end else if (b >= 8'h61 && b <= 8'h66) begin
			v = 5'(b - 8'h61 + 8'd10);
		end else if (b >= 8'h41 && b <= 8'h46) begin
			v = 5'(b - 8'h41 + 8'd10);
		end
		return v;
	endfunction

endpackage

`default_nettype wire

### sv/nsv_apb_regs.sv
// APB register file of the NMEA sentence validator: holds strict_checksum.
// Depends on nothing but the clock and reset.
`default_nettype none

module nsv_apb_regs (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	output logic             strict_checksum
);

	logic strict_q;
	logic hit;

	// Single register at word 0
	assign hit    = (paddr[2] == 1'b0);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strict_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && hit) begin
			strict_q <= pwdata[0];
		end
	end

	// Read back
	always_comb begin
		prdata = '0;
		if (hit) begin
			prdata[0] = strict_q;
		end
	end

	assign strict_checksum = strict_q;

endmodule

`default_nettype wire

### sv/nsv_parser.sv
// Sentence parser: per-sentence state, byte update and verdict logic.
// Depends on nsv_pkg.
`default_nettype none

module nsv_parser
	import nsv_pkg::*;
#(
	parameter int MIN_BODY_LEN = 6
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,        // one item is processed this cycle
	input  wire logic [7:0] step_byte,
	input  wire logic       step_last,   // end marker: give verdict, clear
	input  wire logic       strict_checksum,
	output nsv_result_t     verdict
);

	// Parse phases
	localparam logic [2:0] PH_DOLLAR = 3'd0;
	localparam logic [2:0] PH_BODY   = 3'd1;
	localparam logic [2:0] PH_DIGITS = 3'd2;
	localparam logic [2:0] PH_TERM   = 3'd3;
	localparam logic [2:0] PH_CR     = 3'd4;
	localparam logic [2:0] PH_DONE   = 3'd5;

	localparam logic [2:0] MIN_LEN = 3'(MIN_BODY_LEN);

	logic [2:0] phase_q, phase_d;
	logic [7:0] xor_q, xor_d;
	logic [2:0] cnt_q, cnt_d;
	logic [7:0] exp_q, exp_d;
	logic       digit_q, digit_d;   // one checksum digit already taken
	logic [2:0] err_q, err_d;
	logic [4:0] hv;
	logic [7:0] exp_new;
	logic [2:0] code;

	assign hv      = hex_value(step_byte);
	assign exp_new = {exp_q[3:0], hv[3:0]};

	// Byte update; the first error latched wins
	always_comb begin
		phase_d = phase_q;
		xor_d   = xor_q;
		cnt_d   = cnt_q;
		exp_d   = exp_q;
		digit_d = digit_q;
		err_d   = err_q;
		if (err_q == ERR_OK) begin
			case (phase_q)
				PH_DOLLAR: begin
					if (step_byte == CHAR_DOLLAR) phase_d = PH_BODY;
					else err_d = ERR_NODOLLAR;
				end
				PH_BODY: begin
					if (step_byte == CHAR_STAR) begin
						if (cnt_q < MIN_LEN) err_d = ERR_SHORT;
						else phase_d = PH_DIGITS;
					end else begin
						xor_d = xor_q ^ step_byte;
						if (cnt_q != BODY_CNT_MAX) cnt_d = cnt_q + 3'd1;
					end
				end
				PH_DIGITS: begin
					if (hv[4]) begin
						err_d = ERR_DIGITS;
					end else begin
						exp_d = exp_new;
						if (!digit_q) begin
							digit_d = 1'b1;
						end else if (exp_new == 8'h00) begin
							err_d = ERR_DIGITS;
						end else if (exp_new != xor_q) begin
							err_d = ERR_MISMATCH;
						end else begin
							phase_d = PH_TERM;
						end
					end
				end
				PH_TERM: begin
					if (step_byte == CHAR_CR) phase_d = PH_CR;
					else if (step_byte == CHAR_LF) phase_d = PH_DONE;
					else err_d = ERR_TERM;
				end
				PH_CR: begin
					if (step_byte == CHAR_LF) phase_d = PH_DONE;
					else err_d = ERR_TERM;
				end
				default: err_d = ERR_TERM;
			endcase
		end
	end

	// Verdict from the current state
	always_comb begin
		code = ERR_OK;
		if (err_q != ERR_OK) begin
			code = err_q;
		end else begin
			case (phase_q)
				PH_DOLLAR: code = ERR_NODOLLAR;
				PH_BODY: begin
					if (cnt_q < MIN_LEN) code = ERR_SHORT;
					else if (strict_checksum) code = ERR_STRICT;
					else code = ERR_OK;
				end
				PH_DIGITS: code = ERR_DIGITS;
				PH_CR:     code = ERR_TERM;
				default:   code = ERR_OK;
			endcase
		end
	end

	assign verdict.sentence_ok  = (code == ERR_OK);
	assign verdict.error_code   = code;
	assign verdict.computed_xor = xor_q;

	// Sentence state; cleared after each verdict
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_DOLLAR;
			xor_q   <= 8'h00;
			cnt_q   <= 3'd0;
			exp_q   <= 8'h00;
			digit_q <= 1'b0;
			err_q   <= ERR_OK;
		end else if (step) begin
			if (step_last) begin
				phase_q <= PH_DOLLAR;
				xor_q   <= 8'h00;
				cnt_q   <= 3'd0;
				exp_q   <= 8'h00;
				digit_q <= 1'b0;
				err_q   <= ERR_OK;
			end else begin
				phase_q <= phase_d;
				xor_q   <= xor_d;
				cnt_q   <= cnt_d;
				exp_q   <= exp_d;
				digit_q <= digit_d;
				err_q   <= err_d;
			end
		end
	end

endmodule

`default_nettype wire

### sv/nmea_sentence_validator.sv
// NMEA sentence validator, top level: input register, parser, result register.
// Depends on nsv_pkg, nsv_apb_regs and nsv_parser.
`default_nettype none

// Checks NMEA 0183 sentences fed one byte per transfer on the s_axis side;
// a transfer with s_axis_tlast high carries no byte and ends the sentence.
// For each end marker one result transfer leaves on m_axis with pass/fail,
// the error code and the XOR of the body bytes; the sentence state then
// clears for the next sentence. One byte is taken per clock unless stage 1
// is held: a byte waits in the input register before the parser updates
// its state registers, and a verdict is loaded into the result register,
// which drives m_axis_tvalid directly, when the parser takes its end marker.
// A result waiting in the output register stalls the input only when a
// second end marker reaches the parser. strict_checksum sits at APB
// address 0; the user must write it only while no sentence is in flight,
// and the block itself does not enforce this.
module nmea_sentence_validator
	import nsv_pkg::*;
#(
	parameter int MIN_BODY_LEN = 6
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	// Sentence bytes
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] sentence_byte
	input  wire logic        s_axis_tlast,   // end_marker
	// Verdicts
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [0] sentence_ok, [3:1] error_code, [11:4] computed_xor, [15:12] zero
	output logic [8*RESULT_BYTES-1:0] m_axis_tdata
);

	logic        strict;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic        go_s1;
	logic        out_valid_q;
	nsv_result_t out_q;
	nsv_result_t verdict;

	nsv_apb_regs u_regs (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.strict_checksum (strict)
	);

	// Stage 1 may proceed unless it holds an end marker, the result slot is full and m_axis_tready is low
	assign go_s1         = valid_s1 && (!last_s1 || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || go_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	nsv_parser #(
		.MIN_BODY_LEN (MIN_BODY_LEN)
	) u_parser (
		.clk             (clk),
		.arst_n          (arst_n),
		.step            (go_s1),
		.step_byte       (byte_s1),
		.step_last       (last_s1),
		.strict_checksum (strict),
		.verdict         (verdict)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && last_s1) begin
			out_q <= verdict;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(8*RESULT_BYTES-$bits(nsv_result_t)){1'b0}}, out_q};

endmodule

`default_nettype wire
